[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the page mapper.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define DPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define DPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/dpm_pkg.sv]
// Constants shared by the page mapper RTL and its channel interfaces.
// No dependencies.
package dpm_pkg;

  localparam int ADDR_W = 48;

  // Virtual window that the table covers: [WIN_LO, WIN_HI)
  localparam logic [ADDR_W-1:0] WIN_LO = 48'h0000_2000_0000;
  localparam logic [ADDR_W-1:0] WIN_HI = 48'h0000_4000_0000;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic REG_ALLOC_BASE = 1'b0;  // register index, taken from paddr[3]

endpackage

[rtl/core/dpm_if.sv]
// Valid/ready channel interfaces for requests and results of the page mapper.
// Depends on dpm_pkg.
interface dpm_in_if import dpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] virt_addr;
  logic [ADDR_W-1:0] phys_addr_in;

  modport source (output valid, output virt_addr, output phys_addr_in, input ready);
  modport sink   (input valid, input virt_addr, input phys_addr_in, output ready);
endinterface

interface dpm_out_if import dpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] phys_addr_out;
  logic              out_of_window;
  logic              newly_mapped;

  modport source (output valid, output phys_addr_out, output out_of_window,
                  output newly_mapped, input ready);
  modport sink   (input valid, input phys_addr_out, input out_of_window,
                  input newly_mapped, output ready);
endinterface

[rtl/core/demand_page_mapper_top.sv]
// Demand page mapper: top level with the page table memory and its control.
// Depends on dpm_pkg, dpm_in_if / dpm_out_if and assert_macros.svh.
//
// Translates virtual addresses in the window 0x2000_0000..0x3FFF_FFFF through a
// table of TABLE_ENTRIES page frames, filling an empty entry on first touch with
// the requested frame or, when the request gives 0, with the next frame of a
// bump allocator that starts at alloc_base (APB register 0, byte address 0;
// writing it reloads the allocator). Addresses outside the window return 0 with
// out_of_window set. Each item passes through two steps: a read of the table
// entry into a register, then, once the result register is free, resolving hit
// or fill, writing the entry back and loading the result register. One item is in
// work at a time, so the write-back always lands before the next read. A new item
// is taken while a finished result still waits in the output register. After
// reset the block sweeps all TABLE_ENTRIES entries (8192 by default) once to clear
// every valid bit, one entry per cycle, and takes no item until the sweep is done;
// configuration writes are taken during the sweep.
`include "assert_macros.svh"

module demand_page_mapper_top import dpm_pkg::*; #(
  parameter int TABLE_ENTRIES = 8192,
  parameter int PAGE_SHIFT    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  // channels
  dpm_in_if.sink                in_ch,
  dpm_out_if.source             out_ch
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int FRAME_W = ADDR_W - PAGE_SHIFT;
  localparam int ENTRY_W = FRAME_W + 1;  // {valid, frame}

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;

  // state codes
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0]  alloc_base_r;
  logic [ADDR_W-1:0]  next_free_r, next_free_nxt;
  logic [ADDR_W-1:0]  va_r;
  logic [ADDR_W-1:0]  pa_r;
  logic [ENTRY_W-1:0] tbl_rd_r;

  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_oow_r;
  logic               out_new_r;

  logic               in_acc;
  logic               out_free;
  logic               cfg_wr;
  logic               in_win;
  logic               hit;
  logic               fill;
  logic               take_pool;
  logic               finish;
  logic [FRAME_W-1:0] frame_new;
  logic [FRAME_W-1:0] frame;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  logic [ENTRY_W-1:0] tbl_mem [TABLE_ENTRIES];

  // ---------------------------------------------------------------------------
  // Configuration: one 48-bit register in a 64-bit slot
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[3] == REG_ALLOC_BASE);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[3] == REG_ALLOC_BASE) begin
      cfg_prdata = CFG_DATA_W'(alloc_base_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_base_r <= '0;
    end else if (cfg_wr) begin
      alloc_base_r <= cfg_pwdata[ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  // resolve the looked-up item once the result register can take it
  assign finish      = (state_r == S_LOOK) && out_free;

  // ---------------------------------------------------------------------------
  // Lookup: hit or fill decision on the registered table entry
  // ---------------------------------------------------------------------------
  assign in_win    = (va_r >= WIN_LO) && (va_r < WIN_HI);
  assign hit       = tbl_rd_r[FRAME_W];
  assign fill      = in_win && !hit;
  assign take_pool = (pa_r == '0);
  assign frame_new = take_pool ? next_free_r[ADDR_W-1:PAGE_SHIFT]
                               : pa_r[ADDR_W-1:PAGE_SHIFT];
  assign frame     = hit ? tbl_rd_r[FRAME_W-1:0] : frame_new;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    next_free_nxt = next_free_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (fill && take_pool) begin
            next_free_nxt = next_free_r + PAGE_BYTES;  // wraps at 2^48
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a register write reloads the allocator
    if (cfg_wr) begin
      next_free_nxt = cfg_pwdata[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the accepted request for the lookup cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      va_r <= in_ch.virt_addr;
      pa_r <= in_ch.phys_addr_in;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (finish) begin
      out_addr_r <= in_win ? {frame, va_r[PAGE_SHIFT-1:0]} : '0;
      out_oow_r  <= !in_win;
      out_new_r  <= fill;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.phys_addr_out = out_addr_r;
  assign out_ch.out_of_window = out_oow_r;
  assign out_ch.newly_mapped  = out_new_r;

  // ---------------------------------------------------------------------------
  // Page table memory: clear sweep after reset, write-back on fill
  // ---------------------------------------------------------------------------
  assign mem_we = (state_r == S_CLEAR) || (finish && fill);
  assign mem_wa = (state_r == S_CLEAR) ? clr_cnt_r : va_r[PAGE_SHIFT +: IDX_W];
  assign mem_wd = (state_r == S_CLEAR) ? '0 : {1'b1, frame_new};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tbl_rd_r <= tbl_mem[in_ch.virt_addr[PAGE_SHIFT +: IDX_W]];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DPM_ASSERT(a_oow_zero, clk, rst_n,
    (out_valid_r && out_oow_r) |-> (out_addr_r == '0 && !out_new_r),
    "out-of-window result carries an address or a fill")
  `DPM_ASSERT(a_acc_look, clk, rst_n,
    in_acc |=> (state_r == S_LOOK),
    "accepted item did not enter lookup")
  `DPM_ASSERT(a_alloc_step, clk, rst_n,
    ($past(rst_n) && !$stable(next_free_r))
      |-> ($past(cfg_wr) || next_free_r == $past(next_free_r) + PAGE_BYTES),
    "allocator moved by other than one page")
  `DPM_ASSERT(a_we_state, clk, rst_n,
    mem_we |-> (state_r == S_CLEAR || (state_r == S_LOOK && in_win && !hit)),
    "table written outside sweep or fill")

endmodule

[bench/tb_top.sv]
// Self-checking bench for demand_page_mapper_top: directed and random translation requests,
// with an in-bench page table model that predicts every result.
// Depends on dpm_pkg, dpm_in_if / dpm_out_if and the mapper RTL.
`timescale 1ns / 1ps

module tb_top;
  import dpm_pkg::*;

  localparam int TABLE_ENTRIES  = 8192;
  localparam int PAGE_SHIFT     = 16;
  localparam int IDX_W          = $clog2(TABLE_ENTRIES);
  localparam int FRAME_W        = ADDR_W - PAGE_SHIFT;
  localparam logic [ADDR_W:0] PAGE_STEP = (ADDR_W+1)'(1) << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] OFFSET_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] ALLOC_BASE_ADDR = CFG_ADDR_W'(REG_ALLOC_BASE) << 3;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;   // result side held off this long once
  localparam int MAX_SHOWN      = 10;
  // Longest legal quiet stretch is the table sweep after reset; allow several times that.
  localparam int WATCHDOG_LIMIT = 4 * TABLE_ENTRIES;

  typedef struct packed {
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr_in;
  } xlat_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_addr_out;
    logic              out_of_window;
    logic              newly_mapped;
  } xlat_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dpm_in_if  req_if ();
  dpm_out_if rsp_if ();

  demand_page_mapper_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_ch      (req_if),
    .out_ch     (rsp_if)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Page table model: frames, valid bits and the bump allocator, kept in step
  // with every accepted request and every base register write.
  // ---------------------------------------------------------------------------
  logic [FRAME_W-1:0] page_frame  [TABLE_ENTRIES];
  bit                 page_mapped [TABLE_ENTRIES];
  logic [ADDR_W-1:0]  next_free_m;

  xlat_req_t pending_reqs[$];     // items waiting for the driver
  xlat_rsp_t expected_xlats[$];   // translations owed by the block, oldest first
  logic [IDX_W-1:0] hot_pages[$]; // recently touched pages, reused to provoke hits

  int items_in, results_ok, mismatches;
  int oow_cnt, fresh_cnt, alloc_cnt, wrap_cnt, cfg_writes;

  function automatic xlat_rsp_t translate_va(input xlat_req_t r);
    xlat_rsp_t         res;
    logic [IDX_W-1:0]  slot;
    logic [ADDR_W-1:0] frame_src;
    logic              wrapped;
    res = '0;
    // Outside the window: zero address, flag set, table untouched.
    if (r.virt_addr < WIN_LO || r.virt_addr >= WIN_HI) begin
      res.out_of_window = 1'b1;
      oow_cnt++;
      return res;
    end
    slot = r.virt_addr[PAGE_SHIFT +: IDX_W];
    if (!page_mapped[slot]) begin
      frame_src = r.phys_addr_in;
      // A zero page address draws the next frame from the allocator.
      if (frame_src == '0) begin
        frame_src = next_free_m;
        {wrapped, next_free_m} = {1'b0, next_free_m} + PAGE_STEP;
        alloc_cnt++;
        if (wrapped) wrap_cnt++;
      end
      // Offset bits of the page address are dropped on store.
      page_frame[slot]  = frame_src[ADDR_W-1:PAGE_SHIFT];
      page_mapped[slot] = 1'b1;
      res.newly_mapped  = 1'b1;
      fresh_cnt++;
    end
    res.phys_addr_out = {page_frame[slot], r.virt_addr[PAGE_SHIFT-1:0]};
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: pops pending items, sends them in bursts with random gaps.
  // ---------------------------------------------------------------------------
  int tx_burst_left, tx_gap_left;

  always @(posedge clk) begin : req_driver
    bit        fire;
    bit        take;
    xlat_req_t seen;
    xlat_req_t nxt;
    fire = req_if.valid && req_if.ready;
    if (!rst_n) begin
      req_if.valid        <= 1'b0;
      req_if.virt_addr    <= '0;
      req_if.phys_addr_in <= '0;
      tx_burst_left       <= 0;
      tx_gap_left         <= 0;
    end else begin
      // Predict at acceptance: the block works through items in order.
      if (fire) begin
        seen.virt_addr    = req_if.virt_addr;
        seen.phys_addr_in = req_if.phys_addr_in;
        expected_xlats.push_back(translate_va(seen));
        items_in++;
      end
      // Hold the current item until it is taken, then advance or idle.
      if (!req_if.valid || fire) begin
        take = 1'b0;
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          take = 1'b1;
          nxt  = pending_reqs.pop_front();
          if (tx_burst_left <= 1) begin
            // Half the time no gap, so bursts merge into long busy stretches.
            tx_burst_left <= $urandom_range(1, 24);
            tx_gap_left   <= ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            tx_burst_left <= tx_burst_left - 1;
          end
        end
        req_if.valid <= take;
        if (take) begin
          req_if.virt_addr    <= nxt.virt_addr;
          req_if.phys_addr_in <= nxt.phys_addr_in;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: a rotating stall pattern, reshuffled each time its age counter
  // wraps, and one long hold-off on request from the stimulus.
  // ---------------------------------------------------------------------------
  int         rx_hold_left, rx_hold_served, rx_hold_ticket;
  logic [7:0] rx_pattern;
  logic [5:0] rx_pattern_age;

  always @(posedge clk) begin : rsp_receiver
    if (!rst_n) begin
      rsp_if.ready   <= 1'b0;
      rx_hold_left   <= 0;
      rx_hold_served <= 0;
      rx_pattern     <= 8'hFF;
      rx_pattern_age <= '0;
    end else if (rx_hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_served != rx_hold_ticket) begin
      rsp_if.ready   <= 1'b0;
      rx_hold_served <= rx_hold_ticket;
      rx_hold_left   <= LONG_HOLD;
    end else begin
      rsp_if.ready <= rx_pattern[0];
      if (rx_pattern_age == '1) begin
        rx_pattern     <= ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom());
        rx_pattern_age <= '0;
      end else begin
        rx_pattern     <= {rx_pattern[0], rx_pattern[7:1]};
        rx_pattern_age <= rx_pattern_age + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_monitor
    xlat_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_xlats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected result pa=%h oow=%b new=%b", $realtime,
                   rsp_if.phys_addr_out, rsp_if.out_of_window, rsp_if.newly_mapped);
      end else begin
        want = expected_xlats.pop_front();
        if (rsp_if.phys_addr_out !== want.phys_addr_out ||
            rsp_if.out_of_window !== want.out_of_window ||
            rsp_if.newly_mapped  !== want.newly_mapped) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: mismatch: expected pa=%h oow=%b new=%b, got pa=%h oow=%b new=%b",
                     $realtime, want.phys_addr_out, want.out_of_window, want.newly_mapped,
                     rsp_if.phys_addr_out, rsp_if.out_of_window, rsp_if.newly_mapped);
        end else begin
          results_ok++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no item moves on either channel for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [ADDR_W-1:0] va, input logic [ADDR_W-1:0] pa);
    xlat_req_t r;
    r.virt_addr    = va;
    r.phys_addr_in = pa;
    pending_reqs.push_back(r);
  endtask

  // Wait until the block owes nothing, then let it settle before touching config.
  task automatic drain_all();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_xlats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the allocator base: setup cycle, then access until pready.
  task automatic write_alloc_base(input logic [ADDR_W-1:0] base);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ALLOC_BASE_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(base);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // Writing the base also reloads the allocator.
    next_free_m  = base;
    cfg_writes++;
  endtask

  // Mostly in-window requests: hits on recently used pages, first touches of
  // random pages, and a share of addresses outside the window.
  task automatic queue_random(input int n);
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    logic [IDX_W-1:0]  idx;
    int                pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        case ($urandom_range(2))
          0:       va = 48'($urandom_range(32'h1FFF_FFFF));
          1:       va = rand48() | WIN_HI;
          default: va = ($urandom_range(1) == 0) ? WIN_LO - 48'($urandom_range(1, 4))
                                                 : WIN_HI + 48'($urandom_range(0, 3));
        endcase
      end else begin
        if (pick < 60 && hot_pages.size() != 0) begin
          idx = hot_pages[$urandom_range(hot_pages.size() - 1)];
        end else begin
          idx = IDX_W'($urandom());
          hot_pages.push_back(idx);
          if (hot_pages.size() > 48) void'(hot_pages.pop_front());
        end
        va = WIN_LO | {{(ADDR_W-IDX_W-PAGE_SHIFT){1'b0}}, idx, PAGE_SHIFT'($urandom())};
      end
      case ($urandom_range(4))
        0, 1:    pa = '0;
        2:       pa = rand48();
        3:       pa = rand48() & ~OFFSET_MASK;
        default: pa = 48'($urandom_range(1, 16'hFFFF));
      endcase
      push_req(va, pa);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed cases first, then four random phases, each under its
  // own allocator base.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ADDR_W-1:0] base;
    int                ph;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    rx_hold_ticket      = 0;
    next_free_m         = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Lowest base; the block takes it while its table sweep is still running.
    write_alloc_base('0);

    // Window edges and the extremes of both fields.
    push_req(48'h0,               48'h0);
    push_req(WIN_LO - 1,          48'hFFFF_FFFF_FFFF);
    push_req(WIN_HI,              48'h0);
    push_req(48'hFFFF_FFFF_FFFF,  48'hFFFF_FFFF_FFFF);
    // First touch from the allocator, then a hit that ignores its page address.
    push_req(WIN_LO,              48'h0);
    push_req(48'h0000_2000_FFFF,  48'h0000_1234_0000);
    // Last page of the window with an all-ones, unaligned page address.
    push_req(WIN_HI - 1,          48'hFFFF_FFFF_FFFF);
    push_req(48'h0000_2001_ABCD,  48'h1234_5678_9ABC);
    // Allocation followed back to back by a hit on the same page.
    push_req(48'h0000_2002_0000,  48'h0);
    push_req(48'h0000_2002_8001,  48'h0);
    push_req(48'h0000_2003_0000,  48'h0000_0001_0000);
    // Nonzero page address below one page: maps frame zero, no allocation.
    push_req(48'h0000_2007_0000,  48'h0000_0000_0001);
    drain_all();

    // Highest base: the first allocation takes the top frame, the next wraps.
    write_alloc_base('1);
    push_req(48'h0000_2004_0000,  48'h0);
    push_req(48'h0000_2005_1111,  48'h0);
    drain_all();

    // Unaligned base three pages short of the top: walk the allocator over the wrap.
    write_alloc_base(48'hFFFF_FFFD_2345);
    push_req(48'h0000_2006_0000,  48'h0);
    push_req(48'h0000_2008_0042,  48'h0);
    push_req(48'h0000_2009_8000,  48'h0);
    push_req(48'h0000_200A_FFFF,  48'h0);
    push_req(48'h0000_2006_FFFF,  48'h0);

    for (ph = 0; ph < 4; ph++) begin
      drain_all();
      case (ph)
        0:       base = rand48();
        1:       base = rand48() & ~OFFSET_MASK;
        2:       base = {32'hFFFF_FFC0, 16'($urandom())};
        default: base = rand48();
      endcase
      write_alloc_base(base);
      queue_random(150);
      // Starve the result side while the backlog is offered, so the block
      // fills and pushes back on its input.
      if (ph == 0) rx_hold_ticket <= rx_hold_ticket + 1;
      // Pause the sender until every result is back, then go on.
      drain_all();
      queue_random(145);
    end
    drain_all();

    $display("tb: %0d requests, %0d out of window, %0d new mappings, %0d allocations",
             items_in, oow_cnt, fresh_cnt, alloc_cnt);
    $display("tb: %0d allocator wraps, %0d base writes, %0d results matched, %0d errors",
             wrap_cnt, cfg_writes, results_ok, mismatches);
    if (mismatches == 0 && expected_xlats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
